// File: rtl/core/rde_pkg.sv
package rde_pkg;

  localparam int NUM_W   = 64;
  localparam int RADIX_W = 7;
  localparam int DIGIT_W = 6;
  localparam int POS_W   = 6;
  localparam int TERM_W  = 64;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 7'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 7'd64;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 7'd10;
  localparam logic [CHAR_W-1:0]  CHAR_BASE   = 7'd48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } rde_state_t;

  typedef struct packed {
    logic start;
    logic div_step;
    logic emit;
  } rde_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_full;
    logic quo_zero;
  } rde_sts_t;

endpackage

// File: rtl/core/rde_in_if.sv
interface rde_in_if;
  logic                      valid;
  logic                      ready;
  logic [rde_pkg::NUM_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

// File: rtl/core/rde_out_if.sv
interface rde_out_if;
  logic                        valid;
  logic                        ready;
  logic [rde_pkg::DIGIT_W-1:0] digit;
  logic [rde_pkg::POS_W-1:0]   position;
  logic [rde_pkg::TERM_W-1:0]  term;
  logic [rde_pkg::CHAR_W-1:0]  digit_char;
  logic                        nonzero;
  logic                        last;

  modport source (output valid, output digit, output position, output term,
                  output digit_char, output nonzero, output last, input ready);
  modport sink   (input valid, input digit, input position, input term,
                  input digit_char, input nonzero, input last, output ready);
endinterface

// File: rtl/core/rde_ctrl.sv
module rde_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rde_pkg::rde_sts_t sts,
  output rde_pkg::rde_cmd_t cmd
);
  import rde_pkg::*;

  rde_state_t state_r;
  rde_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.out_full) state_nxt = sts.quo_zero ? ST_IDLE : ST_DIV;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.start    = 1'b0;
    cmd.div_step = 1'b0;
    cmd.emit     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = !sts.out_full;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/rde_dp.sv
module rde_dp #(
  parameter int NUMBER_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [rde_pkg::NUM_W-1:0]     in_number,
  input  logic                          cfg_we,
  input  logic [rde_pkg::RADIX_W-1:0]   cfg_data,
  input  rde_pkg::rde_cmd_t             cmd,
  output rde_pkg::rde_sts_t             sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rde_pkg::DIGIT_W-1:0]   out_digit,
  output logic [rde_pkg::POS_W-1:0]     out_position,
  output logic [rde_pkg::TERM_W-1:0]    out_term,
  output logic [rde_pkg::CHAR_W-1:0]    out_digit_char,
  output logic                          out_nonzero,
  output logic                          out_last
);
  import rde_pkg::*;

  localparam int CNT_W = $clog2(NUMBER_BITS);

  logic [RADIX_W-1:0]     radix_r;
  logic [NUMBER_BITS-1:0] quo_r;
  logic [DIGIT_W-1:0]     rem_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [TERM_W-1:0]      power_r;
  logic [POS_W-1:0]       pos_r;

  logic                   out_valid_r;
  logic [DIGIT_W-1:0]     digit_r;
  logic [POS_W-1:0]       position_r;
  logic [TERM_W-1:0]      term_r;
  logic [CHAR_W-1:0]      digit_char_r;
  logic                   nonzero_r;
  logic                   last_r;

  logic [RADIX_W-1:0]     trial;
  logic                   qbit;
  logic [RADIX_W-1:0]     rem_next;
  logic [TERM_W-1:0]      term_prod;
  logic [TERM_W-1:0]      power_prod;
  logic [RADIX_W-1:0]     radix_sat;

  // restoring divide step, one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, quo_r[NUMBER_BITS-1]};
    qbit     = (trial >= radix_r);
    rem_next = qbit ? (trial - radix_r) : trial;
  end

  assign term_prod  = TERM_W'(rem_r) * power_r;
  assign power_prod = power_r * TERM_W'(radix_r);

  always_comb begin
    if (cfg_data < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (cfg_data > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end else begin
      radix_sat = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= radix_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      quo_r   <= in_number[NUMBER_BITS-1:0];
      rem_r   <= '0;
      cnt_r   <= CNT_W'(NUMBER_BITS - 1);
      power_r <= TERM_W'(1);
      pos_r   <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[NUMBER_BITS-2:0], qbit};
      rem_r <= rem_next[DIGIT_W-1:0];
      cnt_r <= cnt_r - CNT_W'(1);
    end else if (cmd.emit) begin
      rem_r   <= '0;
      cnt_r   <= CNT_W'(NUMBER_BITS - 1);
      power_r <= power_prod;
      pos_r   <= pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      digit_r      <= rem_r;
      position_r   <= pos_r;
      term_r       <= term_prod;
      digit_char_r <= CHAR_BASE + CHAR_W'(rem_r);
      nonzero_r    <= (rem_r != '0);
      last_r       <= (quo_r == '0);
    end
  end

  assign sts.div_done = (cnt_r == '0);
  assign sts.out_full = out_valid_r && !out_ready;
  assign sts.quo_zero = (quo_r == '0);

  assign out_valid      = out_valid_r;
  assign out_digit      = digit_r;
  assign out_position   = position_r;
  assign out_term       = term_r;
  assign out_digit_char = digit_char_r;
  assign out_nonzero    = nonzero_r;
  assign out_last       = last_r;

endmodule

// File: rtl/core/radix_digit_expander.sv
// Radix digit expander.
// in_ch (valid/ready) carries one unsigned number per beat; only its low
// NUMBER_BITS bits are used. out_ch (valid/ready) returns one beat per
// digit, least significant first, with digit, position, term, digit_char,
// nonzero and last; last marks the most significant digit. Zero gives a
// single zero digit. cfg_we/cfg_data write the radix, saturated into 2..64
// (reset value 10); write it only while no number is in flight.
// Each digit comes from a restoring divider that retires one quotient bit
// per cycle over all NUMBER_BITS bits, then emits the remainder as the
// digit. A new number is taken only once the previous one has emitted
// its last digit.
// Results pass through an output register; when the receiver stalls the
// next digit waits finished in the divider until the register frees up.
// Reset (rst_n, synchronous) returns the controller to idle, drops any
// pending result and restores the radix to 10.
module radix_digit_expander #(
  parameter int NUMBER_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  rde_in_if.sink                      in_ch,
  rde_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [rde_pkg::RADIX_W-1:0] cfg_data
);
  import rde_pkg::*;

  rde_cmd_t cmd;
  rde_sts_t sts;

  rde_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rde_dp #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_number      (in_ch.number),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_digit      (out_ch.digit),
    .out_position   (out_ch.position),
    .out_term       (out_ch.term),
    .out_digit_char (out_ch.digit_char),
    .out_nonzero    (out_ch.nonzero),
    .out_last       (out_ch.last)
  );

endmodule

// File: bench/radix_digit_expander_tb.sv
module radix_digit_expander_tb;
  import rde_pkg::*;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [POS_W-1:0]   position;
    logic [TERM_W-1:0]  term;
    logic [CHAR_W-1:0]  digit_char;
    logic               nonzero;
    logic               last;
  } digit_beat_t;

  typedef struct {
    bit                 set_radix;
    logic [RADIX_W-1:0] radix;
    logic [NUM_W-1:0]   number;
    bit                 typed;
    digit_beat_t        beat;
  } dir_row_t;

  localparam logic [NUM_W-1:0] ALL_ONES  = '1;
  localparam logic [NUM_W-1:0] TOP_BIT   = 64'h8000_0000_0000_0000;
  localparam digit_beat_t      ZERO_BEAT = '{6'd0, 6'd0, 64'd0, CHAR_BASE, 1'b0, 1'b1};
  localparam digit_beat_t      NO_BEAT   = '0;
  localparam int               DIR_ROWS  = 22;
  localparam int               PHASES    = 7;
  localparam int               PHASE_LEN = 17;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [RADIX_W-1:0] cfg_data;

  rde_in_if  in_ch ();
  rde_out_if out_ch ();

  radix_digit_expander dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  logic [RADIX_W-1:0] radix_setting;
  digit_beat_t        digit_q[$];
  int                 errors;
  bit                 idle_on;
  int                 stall_left;

  // typed rows carry their single digit; the rest go through the predictor
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{1'b0, 7'd0,   64'd0,                  1'b1, ZERO_BEAT},
    '{1'b0, 7'd0,   64'd9,                  1'b1, '{6'd9, 6'd0, 64'd9, 7'd57, 1'b1, 1'b1}},
    '{1'b0, 7'd0,   64'd10,                 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   ALL_ONES,               1'b0, NO_BEAT},
    '{1'b1, 7'd0,   64'd1,                  1'b1, '{6'd1, 6'd0, 64'd1, 7'd49, 1'b1, 1'b1}},
    '{1'b0, 7'd0,   ALL_ONES,               1'b0, NO_BEAT},
    '{1'b0, 7'd0,   TOP_BIT,                1'b0, NO_BEAT},
    '{1'b1, 7'd1,   64'd5,                  1'b0, NO_BEAT},
    '{1'b0, 7'd0,   64'd0,                  1'b1, ZERO_BEAT},
    '{1'b1, 7'd64,  64'd63,                 1'b1, '{6'd63, 6'd0, 64'd63, 7'd111, 1'b1, 1'b1}},
    '{1'b0, 7'd0,   64'd64,                 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   ALL_ONES,               1'b0, NO_BEAT},
    '{1'b1, 7'd127, 64'd0,                  1'b1, ZERO_BEAT},
    '{1'b0, 7'd0,   ALL_ONES,               1'b0, NO_BEAT},
    '{1'b1, 7'd65,  TOP_BIT,                1'b0, NO_BEAT},
    '{1'b1, 7'd3,   64'hAAAA_AAAA_AAAA_AAAA, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   64'h5555_5555_5555_5555, 1'b0, NO_BEAT},
    '{1'b1, 7'd16,  64'h0123_4567_89AB_CDEF, 1'b0, NO_BEAT},
    '{1'b1, 7'd63,  64'd62,                 1'b1, '{6'd62, 6'd0, 64'd62, 7'd110, 1'b1, 1'b1}},
    '{1'b1, 7'd36,  64'd35,                 1'b1, '{6'd35, 6'd0, 64'd35, 7'd83, 1'b1, 1'b1}},
    '{1'b1, 7'd7,   64'd48,                 1'b0, NO_BEAT},
    '{1'b1, 7'd10,  64'd1000,               1'b0, NO_BEAT}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [RADIX_W-1:0] clamp_radix(logic [RADIX_W-1:0] v);
    if (v < RADIX_MIN) return RADIX_MIN;
    if (v > RADIX_MAX) return RADIX_MAX;
    return v;
  endfunction

  function automatic void expand_number(logic [NUM_W-1:0] number);
    logic [NUM_W-1:0] quo;
    logic [NUM_W-1:0] power;
    logic [NUM_W-1:0] base;
    logic [NUM_W-1:0] d;
    logic [POS_W-1:0] pos;
    digit_beat_t      b;
    quo   = number;
    power = 64'd1;
    base  = NUM_W'(radix_setting);
    pos   = '0;
    do begin
      d            = quo % base;
      quo          = quo / base;
      b.digit      = d[DIGIT_W-1:0];
      b.position   = pos;
      b.term       = d * power;
      b.digit_char = CHAR_BASE + d[CHAR_W-1:0];
      b.nonzero    = (d != 0);
      b.last       = (quo == 0);
      digit_q.push_back(b);
      power = power * base;
      pos   = pos + POS_W'(1);
    end while (quo != 0);
  endfunction

  function automatic logic [NUM_W-1:0] pick_number();
    logic [NUM_W-1:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return raw;
      3:       return NUM_W'($urandom_range(0, 200));
      default: return raw >> $urandom_range(0, 63);
    endcase
  endfunction

  function automatic void report(string field, logic [NUM_W-1:0] want, logic [NUM_W-1:0] got);
    errors++;
    $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
  endfunction

  task automatic send_number(logic [NUM_W-1:0] number);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid  = 1'b0;
      in_ch.number = {$urandom, $urandom};
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid  = 1'b1;
    in_ch.number = number;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (digit_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_radix(logic [RADIX_W-1:0] v);
    cfg_we   = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we        = 1'b0;
    radix_setting = clamp_radix(v);
  endtask

  // receiver stalls
  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready = 1'b0;
        stall_left   = $urandom_range(0, 2);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : digit_check
    digit_beat_t got;
    digit_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.digit, out_ch.position, out_ch.term, out_ch.digit_char,
              out_ch.nonzero, out_ch.last};
      if (digit_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none actual digit %0d position %0d",
                 $time, got.digit, got.position);
      end else begin
        want = digit_q.pop_front();
        if (got.digit !== want.digit)
          report("digit", NUM_W'(want.digit), NUM_W'(got.digit));
        if (got.position !== want.position)
          report("position", NUM_W'(want.position), NUM_W'(got.position));
        if (got.term !== want.term) report("term", want.term, got.term);
        if (got.digit_char !== want.digit_char)
          report("digit_char", NUM_W'(want.digit_char), NUM_W'(got.digit_char));
        if (got.nonzero !== want.nonzero)
          report("nonzero", NUM_W'(want.nonzero), NUM_W'(got.nonzero));
        if (got.last !== want.last)
          report("last", NUM_W'(want.last), NUM_W'(got.last));
      end
    end
  end

  initial begin
    logic [NUM_W-1:0] number;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.number  = '0;
    cfg_we        = 1'b0;
    cfg_data      = RADIX_RESET;
    radix_setting = RADIX_RESET;
    errors        = 0;
    idle_on       = 1'b1;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].set_radix) begin
        drain();
        write_radix(dir_rows[i].radix);
      end
      send_number(dir_rows[i].number);
      if (dir_rows[i].typed) digit_q.push_back(dir_rows[i].beat);
      else expand_number(dir_rows[i].number);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        1:       write_radix(RADIX_MIN);
        2:       write_radix(RADIX_MAX);
        4:       write_radix(RADIX_RESET);
        5:       write_radix(RADIX_W'($urandom_range(3, 63)));
        default: write_radix(RADIX_W'($urandom_range(0, 127)));
      endcase
      idle_on = (ph != PHASES - 1);
      for (int k = 0; k < PHASE_LEN; k++) begin
        number = pick_number();
        send_number(number);
        expand_number(number);
      end
    end

    drain();
    repeat (100) @(negedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
